// ===== rtl/aavr_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the axis-angle rotator.
package aavr_pkg;

  localparam int unsigned IoW         = 18;
  localparam int unsigned IoFrac      = 16;
  localparam int unsigned AngW        = 16;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned CordicFrac  = 30;
  localparam int unsigned CordicLat   = CordicSteps + 2;
  localparam int unsigned MixLat      = 3;
  localparam int unsigned TotalLat    = CordicLat + MixLat;
  localparam int unsigned CrW         = 21;
  localparam int unsigned DotW        = 22;
  localparam int unsigned PaW         = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [IoW-1:0] IoLimit = 18'sd65536;

  typedef logic signed [IoW-1:0] io_t;
  typedef io_t [2:0] vec3_t;

  typedef struct packed {
    vec3_t               v;
    logic [2:0][CrW-1:0] cr;
    logic [2:0][PaW-1:0] pa;
  } vterm_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] r;
    unique case (idx)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/aavr_cordic.sv =====
// Pipelined rotation-mode CORDIC: one register per iteration, sine and cosine out.
module aavr_cordic import aavr_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [AngW-1:0]            angle_i,
  output logic signed [FracBits+1:0] sin_o,
  output logic signed [FracBits+1:0] cos_o
);

  localparam int unsigned Sh = CordicFrac - FracBits;
  localparam int unsigned OW = FracBits + 2;
  localparam logic signed [34:0] One35 = 35'sd1 <<< FracBits;

  logic signed [33:0] x_q [0:CordicSteps];
  logic signed [33:0] y_q [0:CordicSteps];
  logic signed [32:0] z_q [0:CordicSteps];
  logic [1:0]         quad_q [0:CordicSteps];
  logic               zero_q [0:CordicSteps];
  logic signed [OW-1:0] sin_q, cos_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CordicGain;
      y_q[0]    <= '0;
      z_q[0]    <= {3'b000, angle_i[AngW-3:0], 16'd0};
      quad_q[0] <= angle_i[AngW-1:AngW-2];
      zero_q[0] <= (angle_i[AngW-3:0] == '0);
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_iter
    logic signed [32:0] at;
    assign at = $signed({3'b000, atan_turn(5'(i))});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][32]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + at;
        end
        quad_q[i+1] <= quad_q[i];
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  logic signed [34:0] xr, yr, xc, yc;
  logic signed [OW-1:0] c0, s0, sin_d, cos_d;

  if (Sh == 0) begin : g_noround
    assign xr = 35'(x_q[CordicSteps]);
    assign yr = 35'(y_q[CordicSteps]);
  end else begin : g_round
    assign xr = (35'(x_q[CordicSteps]) + (35'sd1 <<< (Sh - 1))) >>> Sh;
    assign yr = (35'(y_q[CordicSteps]) + (35'sd1 <<< (Sh - 1))) >>> Sh;
  end

  always_comb begin
    xc = (xr > One35) ? One35 : ((xr < -One35) ? -One35 : xr);
    yc = (yr > One35) ? One35 : ((yr < -One35) ? -One35 : yr);
    if (zero_q[CordicSteps]) begin
      c0 = OW'(One35);
      s0 = '0;
    end else begin
      c0 = xc[OW-1:0];
      s0 = yc[OW-1:0];
    end
    unique case (quad_q[CordicSteps])
      2'd0: begin cos_d = c0;  sin_d = s0;  end
      2'd1: begin cos_d = -s0; sin_d = c0;  end
      2'd2: begin cos_d = -c0; sin_d = -s0; end
      default: begin cos_d = s0; sin_d = -c0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== rtl/aavr_vec.sv =====
// Cross product, dot product and projection terms, delayed to meet the CORDIC output.
module aavr_vec import aavr_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  vec3_t  axis_i,
  input  vec3_t  vec_i,
  output vterm_t term_o
);

  localparam int unsigned Dly = CordicLat - 2;

  vec3_t               a1_q, v1_q;
  logic [2:0][CrW-1:0] cr1_q;
  logic signed [DotW-1:0] dt1_q;
  vterm_t              pipe_q [0:Dly];

  logic signed [36:0] crf [3];
  logic signed [37:0] dtf;
  logic signed [39:0] paf [3];

  always_comb begin
    crf[0] = 37'(axis_i[1] * vec_i[2]) - 37'(axis_i[2] * vec_i[1]) + 37'sd32768;
    crf[1] = 37'(axis_i[2] * vec_i[0]) - 37'(axis_i[0] * vec_i[2]) + 37'sd32768;
    crf[2] = 37'(axis_i[0] * vec_i[1]) - 37'(axis_i[1] * vec_i[0]) + 37'sd32768;
    dtf = 38'(axis_i[0] * vec_i[0]) + 38'(axis_i[1] * vec_i[1])
        + 38'(axis_i[2] * vec_i[2]) + 38'sd32768;
    for (int j = 0; j < 3; j++) begin
      paf[j] = 40'(dt1_q * a1_q[j]) + 40'sd32768;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= axis_i;
      v1_q  <= vec_i;
      dt1_q <= dtf[37:IoFrac];
      for (int j = 0; j < 3; j++) begin
        cr1_q[j] <= crf[j][36:IoFrac];
      end
      pipe_q[0].v  <= v1_q;
      pipe_q[0].cr <= cr1_q;
      for (int j = 0; j < 3; j++) begin
        pipe_q[0].pa[j] <= paf[j][39:IoFrac];
      end
      for (int d = 1; d <= Dly; d++) begin
        pipe_q[d] <= pipe_q[d-1];
      end
    end
  end

  assign term_o = pipe_q[Dly];

endmodule

// ===== rtl/aavr_mix.sv =====
// Weighted sum of the three Rodrigues terms, rounding and saturation, three stages.
module aavr_mix import aavr_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [FracBits+1:0] sin_i,
  input  logic signed [FracBits+1:0] cos_i,
  input  vterm_t                     term_i,
  output vec3_t                      rot_o
);

  localparam int unsigned AW = FracBits + 29;
  localparam logic signed [AW-1:0] Half = AW'(1) <<< (FracBits - 1);
  localparam logic signed [AW-1:0] Lim  = AW'(65536);

  logic signed [FracBits+2:0] k;
  logic signed [AW-1:0] pc_q [3], ps_q [3], pk_q [3], acc_q [3], rs [3];
  vec3_t rot_q;

  assign k = (FracBits+3)'(1) <<< FracBits;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rs[j] = (acc_q[j] + Half) >>> FracBits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        pc_q[j] <= AW'(cos_i * term_i.v[j]);
        ps_q[j] <= AW'(sin_i * $signed(term_i.cr[j]));
        pk_q[j] <= AW'((k - (FracBits+3)'(cos_i)) * $signed(term_i.pa[j]));
        acc_q[j] <= pc_q[j] + ps_q[j] + pk_q[j];
        if (rs[j] > Lim) begin
          rot_q[j] <= IoLimit;
        end else if (rs[j] < -Lim) begin
          rot_q[j] <= -IoLimit;
        end else begin
          rot_q[j] <= rs[j][IoW-1:0];
        end
      end
    end
  end

  assign rot_o = rot_q;

endmodule

// ===== rtl/axis_angle_vector_rotation_top.sv =====
// Pipeline stages from input request to result: 1 setup, 30 CORDIC, 1 sin/cos, 3 mix.
// Throughput: one request per cycle; the whole pipeline holds while a result waits
// unaccepted at the output, so an input request is taken whenever the output is free.
// Reset: clears only the stage valid bits; no result is offered after reset.
// Sine and cosine come from a 30-iteration CORDIC with one register per iteration.
module axis_angle_vector_rotation_top import aavr_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // axis_x, axis_y, axis_z, vec_x, vec_y, vec_z, turn_angle, zero pad
  input  logic [127:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // rot_x, rot_y, rot_z, zero pad
  output logic [55:0]  m_axis_tdata_o
);

  logic en;
  logic [TotalLat-1:0] vld_q, vld_d;
  vec3_t axis, vec, rot;
  logic signed [FRACTION_BITS+1:0] sn, cs;
  vterm_t term;

  assign en = !vld_q[TotalLat-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  for (genvar j = 0; j < 3; j++) begin : g_unpack
    assign axis[j] = s_axis_tdata_i[j*IoW +: IoW];
    assign vec[j]  = s_axis_tdata_i[(j+3)*IoW +: IoW];
  end

  assign vld_d = {vld_q[TotalLat-2:0], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  aavr_cordic #(.FracBits(FRACTION_BITS)) u_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (s_axis_tdata_i[6*IoW +: AngW]),
    .sin_o   (sn),
    .cos_o   (cs)
  );

  aavr_vec u_vec (
    .clk_i  (clk_i),
    .en_i   (en),
    .axis_i (axis),
    .vec_i  (vec),
    .term_o (term)
  );

  aavr_mix #(.FracBits(FRACTION_BITS)) u_mix (
    .clk_i  (clk_i),
    .en_i   (en),
    .sin_i  (sn),
    .cos_i  (cs),
    .term_i (term),
    .rot_o  (rot)
  );

  assign m_axis_tvalid_o = vld_q[TotalLat-1];
  assign m_axis_tdata_o  = {2'b00, rot[2], rot[1], rot[0]};

endmodule
